// File: hdl/minmax_normalized_colormap_unit_defines.svh
// Assertion macros for the colormap unit.
`ifndef MINMAX_NORMALIZED_COLORMAP_UNIT_DEFINES_SVH
`define MINMAX_NORMALIZED_COLORMAP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MNC_ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define MNC_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define MNC_ASSERT_IMPL(label, clk, rst, prop)
`define MNC_ASSERT_NORST(label, clk, prop)
`endif
`endif

// File: hdl/mnc_pkg.sv
// Shared types, constants and palette tables for the colormap unit.
package mnc_pkg;
  localparam int SampleBits = 16;
  localparam int FracBits   = 8;
  localparam int PalSize    = 32;
  localparam int IdxBits    = 5;
  localparam int DiffBits   = SampleBits + 1;
  localparam int NumBits    = DiffBits + IdxBits + FracBits;
  localparam int QuoBits    = IdxBits + FracBits;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_SCAN  = 2'd1;
  localparam logic [1:0] OP_MAP   = 2'd2;

  typedef struct packed {
    logic clear;
    logic scan;
    logic map_start;
    logic div_step;
    logic out_load;
  } mnc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic empty;
  } mnc_sts_t;

  // Palette entry packed {r,g,b}.
  function automatic logic [23:0] jet_rgb(input logic [IdxBits-1:0] i);
    logic [23:0] v;
    case (i)
      5'd0: v = 24'h0000A0; 5'd1: v = 24'h0000C0; 5'd2: v = 24'h0000E0;
      5'd3: v = 24'h0000FF; 5'd4: v = 24'h0020FF; 5'd5: v = 24'h0040FF;
      5'd6: v = 24'h0060FF; 5'd7: v = 24'h0080FF; 5'd8: v = 24'h00A0FF;
      5'd9: v = 24'h00C0FF; 5'd10: v = 24'h00E0FF; 5'd11: v = 24'h00FFFF;
      5'd12: v = 24'h20FFE0; 5'd13: v = 24'h40FFC0; 5'd14: v = 24'h60FFA0;
      5'd15: v = 24'h80FF80; 5'd16: v = 24'hA0FF60; 5'd17: v = 24'hC0FF40;
      5'd18: v = 24'hE0FF20; 5'd19: v = 24'hFFFF00; 5'd20: v = 24'hFFE000;
      5'd21: v = 24'hFFC000; 5'd22: v = 24'hFFA000; 5'd23: v = 24'hFF8000;
      5'd24: v = 24'hFF6000; 5'd25: v = 24'hFF4000; 5'd26: v = 24'hFF2000;
      5'd27: v = 24'hFF0000; 5'd28: v = 24'hE00000; 5'd29: v = 24'hC00000;
      5'd30: v = 24'hA00000; default: v = 24'h800000;
    endcase
    return v;
  endfunction

  function automatic logic [23:0] hot_rgb(input logic [IdxBits-1:0] i);
    logic [23:0] v;
    case (i)
      5'd0: v = 24'h150000; 5'd1: v = 24'h2B0000; 5'd2: v = 24'h400000;
      5'd3: v = 24'h550000; 5'd4: v = 24'h6B0000; 5'd5: v = 24'h800000;
      5'd6: v = 24'h950000; 5'd7: v = 24'hAB0000; 5'd8: v = 24'hC00000;
      5'd9: v = 24'hD50000; 5'd10: v = 24'hEB0000; 5'd11: v = 24'hFF0000;
      5'd12: v = 24'hFF1500; 5'd13: v = 24'hFF2B00; 5'd14: v = 24'hFF4000;
      5'd15: v = 24'hFF5500; 5'd16: v = 24'hFF6B00; 5'd17: v = 24'hFF8000;
      5'd18: v = 24'hFF9500; 5'd19: v = 24'hFFAB00; 5'd20: v = 24'hFFC000;
      5'd21: v = 24'hFFD500; 5'd22: v = 24'hFFEB00; 5'd23: v = 24'hFFFF00;
      5'd24: v = 24'hFFFF20; 5'd25: v = 24'hFFFF40; 5'd26: v = 24'hFFFF60;
      5'd27: v = 24'hFFFF80; 5'd28: v = 24'hFFFFA0; 5'd29: v = 24'hFFFFC0;
      5'd30: v = 24'hFFFFE0; default: v = 24'hFFFFFF;
    endcase
    return v;
  endfunction
endpackage

// File: hdl/minmax_normalized_colormap_unit.sv
// Top level of the min-max normalized colormap unit.
// Clear and scan transfers give no result.
// Map: the divider runs 13 steps, one quotient bit a cycle, then the blended
// pixel loads into the output registers once the output is free; next input is taken back in idle.
// One item is in work at a time; the divider loop sets the rate.
// Synchronous active-high rst zeroes min/max and palette, sets the empty flag.
module minmax_normalized_colormap_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic                                  cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            opcode,
  input  logic signed [mnc_pkg::SampleBits-1:0] sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [7:0]                            blue,
  output logic [7:0]                            green,
  output logic [7:0]                            red
);
  import mnc_pkg::*;
  `include "minmax_normalized_colormap_unit_defines.svh"

  mnc_cmd_t cmd;
  mnc_sts_t sts;
  logic     palette_select;

  // Palette select register; the user must write it only while idle (the block does not enforce this).
  always_ff @(posedge clk) begin
    if (rst) palette_select <= 1'b0;
    else if (cfg_we) palette_select <= cfg_wdata;
  end

  mnc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .opcode, .in_ready, .out_valid, .out_ready,
    .cmd, .sts
  );

  mnc_dpath u_dpath (
    .clk, .rst, .palette_select, .sample, .cmd, .sts, .blue, .green, .red
  );

  // Clear and scan never start a division.
  `MNC_ASSERT_IMPL(a_one_cmd, clk, rst, $onehot0({cmd.clear, cmd.scan, cmd.map_start}))
  // No transfer is taken while a map is in the divider.
  `MNC_ASSERT_IMPL(a_busy, clk, rst, cmd.div_step |-> !in_ready)
  // A result loads only after the divider finished.
  `MNC_ASSERT_IMPL(a_load, clk, rst, cmd.out_load |-> $past(sts.div_done))
endmodule

// File: hdl/mnc_ctrl.sv
// Controller state machine for the colormap unit.
module mnc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        opcode,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mnc_pkg::mnc_cmd_t cmd,
  input  mnc_pkg::mnc_sts_t sts
);
  import mnc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   acc;
  logic   out_take;

  assign out_take = out_valid && out_ready;
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.clear     = acc && opcode == OP_CLEAR;
    cmd.scan      = acc && opcode == OP_SCAN;
    cmd.map_start = acc && opcode == OP_MAP;
    case (state)
      S_IDLE: begin
        if (cmd.map_start) state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
    end
  end
endmodule

// File: hdl/mnc_dpath.sv
// Datapath: min/max registers, restoring divider, palette blend.
module mnc_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              palette_select,
  input  logic signed [mnc_pkg::SampleBits-1:0] sample,
  input  mnc_pkg::mnc_cmd_t                 cmd,
  output mnc_pkg::mnc_sts_t                 sts,
  output logic [7:0]                        blue,
  output logic [7:0]                        green,
  output logic [7:0]                        red
);
  import mnc_pkg::*;

  localparam int CntBits = $clog2(QuoBits + 1);

  logic signed [SampleBits-1:0] run_min, run_max;
  logic                         empty;
  logic                         map_empty;
  logic [NumBits-1:0]           num;
  logic [NumBits-1:0]           num_init;
  logic [DiffBits:0]            rem;
  logic [DiffBits-1:0]          den;
  logic [QuoBits-1:0]           quo;
  logic [CntBits-1:0]           cnt;
  logic signed [SampleBits-1:0] xs;
  logic [DiffBits-1:0]          diff;
  logic [DiffBits:0]            rem_sh;
  logic [IdxBits-1:0]           idx, nxt;
  logic [FracBits-1:0]          frac;
  logic [23:0]                  c0, c1;
  logic [FracBits:0]            w0;
  logic [7:0]                   mix [3];

  always_comb begin
    xs = sample;
    if (sample < run_min) xs = run_min;
    if (sample > run_max) xs = run_max;
    diff = DiffBits'(signed'({xs[SampleBits-1], xs}) -
                     signed'({run_min[SampleBits-1], run_min}));
  end

  assign sts.empty    = empty;
  assign sts.div_done = (cnt == CntBits'(QuoBits - 1));
  assign rem_sh       = {rem[DiffBits-1:0], num[NumBits-1]};
  assign num_init     = NumBits'({diff, FracBits'(0)} * 31);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min <= '0;
      run_max <= '0;
      empty   <= 1'b1;
    end else if (cmd.clear) begin
      run_min <= '0;
      run_max <= '0;
      empty   <= 1'b1;
    end else if (cmd.scan) begin
      empty <= 1'b0;
      if (empty || sample < run_min) run_min <= sample;
      if (empty || sample > run_max) run_max <= sample;
    end
  end

  // Restoring division, one quotient bit per cycle. Quotient < 32*256, so
  // the numerator bits above the low QuoBits preload the remainder.
  always_ff @(posedge clk) begin
    if (cmd.map_start) begin
      num       <= num_init << (NumBits - QuoBits);
      rem       <= {1'b0, num_init[NumBits-1:QuoBits]};
      den       <= DiffBits'({run_max[SampleBits-1], run_max} -
                             {run_min[SampleBits-1], run_min}) + DiffBits'(1);
      quo       <= '0;
      cnt       <= '0;
      map_empty <= empty;
    end else if (cmd.div_step) begin
      num <= num << 1;
      cnt <= cnt + CntBits'(1);
      if (rem_sh >= {1'b0, den}) begin
        rem <= rem_sh - {1'b0, den};
        quo <= {quo[QuoBits-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[QuoBits-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    idx  = map_empty ? '0 : quo[QuoBits-1:FracBits];
    frac = map_empty ? '0 : quo[FracBits-1:0];
    nxt  = (frac != 0 && idx != IdxBits'(PalSize - 1)) ? idx + IdxBits'(1) : idx;
    c0   = palette_select ? hot_rgb(idx) : jet_rgb(idx);
    c1   = palette_select ? hot_rgb(nxt) : jet_rgb(nxt);
    w0   = (FracBits + 1)'(1 << FracBits) - {1'b0, frac};
    for (int c = 0; c < 3; c++) begin
      mix[c] = 8'((({8'd0, c0[c*8 +: 8]} * 16'(w0)) +
                   ({8'd0, c1[c*8 +: 8]} * 16'(frac))) >> FracBits);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      blue  <= mix[0];
      green <= mix[1];
      red   <= mix[2];
    end
  end
endmodule
